// File: hw/rtl/rar_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package rar_pkg;
    localparam int unsigned WORD_WIDTH_DEF = 32;
    localparam int unsigned FIELD_WIDTH    = 32;
    localparam int unsigned CMD_WIDTH      = 3;

    typedef enum logic [CMD_WIDTH-1:0] {
        CMD_ADD = 3'd0,
        CMD_SUB = 3'd1,
        CMD_MUL = 3'd2,
        CMD_DIV = 3'd3,
        CMD_INC = 3'd4
    } t_cmd;

    // request from the sequencer to the shared multiply-add unit
    typedef struct packed {
        logic start;
        logic subtract;
    } t_mac_ctl;
endpackage
`default_nettype wire

// File: hw/rtl/rar_mac.sv
`timescale 1ns / 1ps
`default_nettype none
// Registered multiply-accumulate: o_prod = x*y, or r_acc +/- x*y if acc set, mod 2^W.
module rar_mac #(
    parameter int unsigned WORD_WIDTH = rar_pkg::WORD_WIDTH_DEF
) (
    input  wire                   i_clk,
    input  wire [WORD_WIDTH-1:0]  i_x,
    input  wire [WORD_WIDTH-1:0]  i_y,
    input  wire                   i_acc,
    input  wire                   i_sub,
    input  wire                   i_en,
    output logic [WORD_WIDTH-1:0] o_prod
);
    import rar_pkg::*;
    logic [WORD_WIDTH-1:0] r_prod;
    logic [WORD_WIDTH-1:0] r_acc;
    logic [WORD_WIDTH-1:0] n_prod;
    logic                  r_acc_q;
    logic                  r_sub_q;

    // pipeline: product registered, then accumulate
    assign n_prod = WORD_WIDTH'(i_x * i_y);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod  <= n_prod;
            r_acc_q <= i_acc;
            r_sub_q <= i_sub;
            r_acc   <= o_prod;
        end
    end

    always_comb begin
        if (!r_acc_q) begin
            o_prod = r_prod;
        end else if (r_sub_q) begin
            o_prod = r_acc - r_prod;
        end else begin
            o_prod = r_acc + r_prod;
        end
    end
endmodule
`default_nettype wire

// File: hw/rtl/rar_sub.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared subtract/compare unit for the gcd and restoring divide steps.
module rar_sub #(
    parameter int unsigned WORD_WIDTH = rar_pkg::WORD_WIDTH_DEF
) (
    input  wire  [WORD_WIDTH:0]   i_x,
    input  wire  [WORD_WIDTH:0]   i_y,
    output logic [WORD_WIDTH:0]   o_diff,
    output logic                  o_ge
);
    import rar_pkg::*;
    logic [WORD_WIDTH+1:0] w_full;
    assign w_full = {1'b0, i_x} - {1'b0, i_y};
    assign o_diff = w_full[WORD_WIDTH:0];
    assign o_ge   = ~w_full[WORD_WIDTH+1];
endmodule
`default_nettype wire

// File: hw/rtl/rational_arithmetic_reduce_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Rational arithmetic with reduction.
// Input channel: i_valid / o_stall carry the command and two fractions a, b.
// Output channel: o_valid / i_stall carry the reduced numerator/denominator.
// A transaction is taken when valid is high and stall is low.
// One transaction is worked at a time: o_stall stays high from acceptance
// until the result has been taken by the receiver.
// From acceptance to o_valid: products form in states M0 to M3 through
// one shared multiplier (M0 only for increment and unused codes), then a
// normalize step, a gcd load step and binary gcd steps on one subtract unit,
// then two restoring divisions of W quotient bits each on the same unit.
// The number of gcd steps depends on the operands.
// A zero numerator or denominator skips the gcd steps and divisions: the
// sequencer goes from S_GCD straight to S_OUT.
// The result is held in an output register until i_stall is low; the next
// transaction can be taken in the cycle after that.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// any transaction in progress.
module rational_arithmetic_reduce_top #(
    parameter int unsigned WORD_WIDTH = rar_pkg::WORD_WIDTH_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_valid,
    output logic                              o_stall,
    input  wire  [rar_pkg::CMD_WIDTH-1:0]     i_command,
    input  wire  signed [rar_pkg::FIELD_WIDTH-1:0] i_a_numerator,
    input  wire  signed [rar_pkg::FIELD_WIDTH-1:0] i_a_denominator,
    input  wire  signed [rar_pkg::FIELD_WIDTH-1:0] i_b_numerator,
    input  wire  signed [rar_pkg::FIELD_WIDTH-1:0] i_b_denominator,
    output logic                              o_valid,
    input  wire                               i_stall,
    output logic signed [rar_pkg::FIELD_WIDTH-1:0] o_result_numerator,
    output logic signed [rar_pkg::FIELD_WIDTH-1:0] o_result_denominator
);
    import rar_pkg::*;

    localparam int unsigned W  = WORD_WIDTH;
    localparam int unsigned CW = $clog2(W + 1);
    localparam int unsigned FW = FIELD_WIDTH;

    typedef enum logic [3:0] {
        S_IDLE, S_M0, S_M1, S_M2, S_M3, S_NORM, S_GCD, S_DIVN, S_DIVD, S_OUT
    } t_state;

    t_state              r_state;
    logic [CMD_WIDTH-1:0] r_cmd;
    logic [W-1:0]        r_an, r_ad, r_bn, r_bd;
    logic [W-1:0]        r_n, r_d;
    logic [W:0]          r_u, r_v, r_g;
    logic [CW-1:0]       r_shift;
    logic [W:0]          r_rem;
    logic [W-1:0]        r_quo;
    logic [W-1:0]        r_dividend;
    logic [CW-1:0]       r_cnt;
    logic                r_nneg, r_dneg;
    logic [FW-1:0]       r_out_n, r_out_d;

    logic [W-1:0]        w_mx, w_my;
    logic                w_macc, w_men;
    t_mac_ctl            w_ctl;
    logic [W-1:0]        w_prod;
    logic [W:0]          w_sx, w_sy, w_diff;
    logic                w_ge;
    logic [W:0]          w_rem_sh;
    logic [W-1:0]        w_nmag, w_dmag;

    function automatic logic [W-1:0] to_word(input logic [FW-1:0] f);
        logic [W+FW-1:0] ext;
        ext = {{W{f[FW-1]}}, f};
        return ext[W-1:0];
    endfunction

    function automatic logic [FW-1:0] to_field(input logic [W-1:0] x);
        logic [W+FW-1:0] ext;
        ext = {{FW{x[W-1]}}, x};
        return ext[FW-1:0];
    endfunction

    rar_mac #(.WORD_WIDTH(W)) u_mac (
        .i_clk  (i_clk),
        .i_x    (w_mx),
        .i_y    (w_my),
        .i_acc  (w_ctl.start ? 1'b0 : w_macc),
        .i_sub  (w_ctl.subtract),
        .i_en   (w_men),
        .o_prod (w_prod)
    );

    rar_sub #(.WORD_WIDTH(W)) u_sub (
        .i_x    (w_sx),
        .i_y    (w_sy),
        .o_diff (w_diff),
        .o_ge   (w_ge)
    );

    assign w_nmag   = r_n[W-1] ? W'(-r_n) : r_n;
    assign w_dmag   = r_d[W-1] ? W'(-r_d) : r_d;
    assign w_rem_sh = {r_rem[W-1:0], r_dividend[W-1]};

    // multiplier operands: M0 an*bd (or an*bn), M1 ad*bn, M2 ad*bd (or ad*bn)
    always_comb begin
        w_mx   = r_an;
        w_my   = r_bd;
        w_macc = 1'b0;
        w_men  = 1'b0;
        w_ctl  = '{start: 1'b0, subtract: r_cmd == CMD_SUB};
        case (r_state)
            S_M0: begin
                w_men       = 1'b1;
                w_ctl.start = 1'b1;
                w_my        = (r_cmd == CMD_MUL) ? r_bn : r_bd;
            end
            S_M1: begin
                w_men  = 1'b1;
                w_mx   = r_ad;
                w_my   = r_bn;
                w_macc = 1'b1;
            end
            S_M2: begin
                w_men = 1'b1;
                w_mx  = r_ad;
                w_my  = (r_cmd == CMD_DIV) ? r_bn : r_bd;
            end
            default: begin
            end
        endcase
    end

    // subtract unit operands
    always_comb begin
        w_sx = r_u;
        w_sy = r_v;
        case (r_state)
            S_DIVN, S_DIVD: begin
                w_sx = w_rem_sh;
                w_sy = r_g;
            end
            default: begin
            end
        endcase
    end

    assign o_stall            = (r_state != S_IDLE);
    assign o_valid            = (r_state == S_OUT);
    assign o_result_numerator   = r_out_n;
    assign o_result_denominator = r_out_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd <= i_command;
                        r_an  <= to_word(i_a_numerator);
                        r_ad  <= to_word(i_a_denominator);
                        r_bn  <= to_word(i_b_numerator);
                        r_bd  <= to_word(i_b_denominator);
                        r_state <= S_M0;
                    end
                end
                S_M0: begin
                    case (r_cmd)
                        CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV: begin
                            r_state <= S_M1;
                        end
                        CMD_INC: begin
                            r_n     <= r_an + r_ad;
                            r_d     <= r_ad;
                            r_state <= S_NORM;
                        end
                        default: begin
                            r_n     <= r_an;
                            r_d     <= r_ad;
                            r_state <= S_NORM;
                        end
                    endcase
                end
                S_M1: begin
                    // product 1 now visible; for mul/div it is n
                    if (r_cmd == CMD_MUL || r_cmd == CMD_DIV) begin
                        r_n <= w_prod;
                    end
                    r_state <= S_M2;
                end
                S_M2: begin
                    // accumulated n (add/sub) visible now
                    if (r_cmd == CMD_ADD || r_cmd == CMD_SUB) begin
                        r_n <= w_prod;
                    end
                    r_state <= S_M3;
                end
                S_M3: begin
                    r_d     <= w_prod;
                    r_state <= S_NORM;
                end
                S_NORM: begin
                    if (r_d[W-1]) begin
                        r_n <= W'(-r_n);
                        r_d <= W'(-r_d);
                    end
                    r_state <= S_GCD;
                    r_shift <= '0;
                    r_cnt   <= '0;
                end
                S_GCD: begin
                    // first cycle of gcd: load magnitudes; later steps binary gcd
                    if (r_n == '0 || r_d == '0) begin
                        r_out_n <= to_field(r_n);
                        r_out_d <= to_field(r_d);
                        r_state <= S_OUT;
                    end else if (r_shift == '0 && r_cnt != CW'(1)) begin
                        r_u     <= {1'b0, w_nmag};
                        r_v     <= {1'b0, w_dmag};
                        r_nneg  <= r_n[W-1];
                        r_dneg  <= r_d[W-1];
                        r_cnt   <= CW'(1);
                        r_shift <= CW'(0);
                        r_state <= S_GCD;
                    end else begin
                        if (r_u == r_v) begin
                            r_g        <= r_u << r_shift;
                            r_rem      <= '0;
                            r_dividend <= w_nmag;
                            r_cnt      <= CW'(W);
                            r_state    <= S_DIVN;
                        end else if (!r_u[0] && !r_v[0]) begin
                            r_u     <= r_u >> 1;
                            r_v     <= r_v >> 1;
                            r_shift <= r_shift + CW'(1);
                        end else if (!r_u[0]) begin
                            r_u <= r_u >> 1;
                        end else if (!r_v[0]) begin
                            r_v <= r_v >> 1;
                        end else if (w_ge) begin
                            r_u <= w_diff;
                        end else begin
                            // swap so the larger value sits in u
                            r_u <= r_v;
                            r_v <= r_u;
                        end
                    end
                end
                S_DIVN, S_DIVD: begin
                    if (w_ge) begin
                        r_quo <= {r_quo[W-2:0], 1'b1};
                    end else begin
                        r_quo <= {r_quo[W-2:0], 1'b0};
                    end
                    if (r_cnt == CW'(1)) begin
                        r_rem <= '0;
                        if (r_state == S_DIVN) begin
                            r_out_n <= to_field(r_nneg ?
                                W'(-{r_quo[W-2:0], w_ge}) : {r_quo[W-2:0], w_ge});
                            r_dividend <= w_dmag;
                            r_cnt      <= CW'(W);
                            r_state    <= S_DIVD;
                        end else begin
                            r_out_d <= to_field(r_dneg ?
                                W'(-{r_quo[W-2:0], w_ge}) : {r_quo[W-2:0], w_ge});
                            r_cnt   <= '0;
                            r_state <= S_OUT;
                        end
                    end else begin
                        r_dividend <= r_dividend << 1;
                        r_rem      <= w_ge ? w_diff : w_rem_sh;
                        r_cnt      <= r_cnt - CW'(1);
                    end
                end
                S_OUT: begin
                    if (!i_stall) begin
                        r_state <= S_IDLE;
                        r_cnt   <= '0;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_numerator)
            && $stable(o_result_denominator))
        else $error("result changed while stalled");
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while result pending");
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> r_state == S_M0)
        else $error("accepted transaction not started");
    a_gcd_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DIVN |-> r_g != '0)
        else $error("zero divisor in reduction");
endmodule
`default_nettype wire

// File: verif/tb.sv
`timescale 1ns / 1ps
module tb;
    import rar_pkg::*;

    localparam int W = 32;
    localparam int N_RANDOM = 1000;
    // command codes outside the defined set pass a through to the reduction
    localparam logic [CMD_WIDTH-1:0] CMD_SPARE_LO = 3'd5;
    localparam logic [CMD_WIDTH-1:0] CMD_SPARE_HI = 3'd7;

    typedef struct {
        logic [2:0]   command;
        logic [W-1:0] an;
        logic [W-1:0] ad;
        logic [W-1:0] bn;
        logic [W-1:0] bd;
    } t_op;

    typedef struct {
        logic [W-1:0] num;
        logic [W-1:0] den;
    } t_frac;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic [CMD_WIDTH-1:0] i_command = '0;
    logic signed [FIELD_WIDTH-1:0] i_a_numerator = '0;
    logic signed [FIELD_WIDTH-1:0] i_a_denominator = '0;
    logic signed [FIELD_WIDTH-1:0] i_b_numerator = '0;
    logic signed [FIELD_WIDTH-1:0] i_b_denominator = '0;
    logic o_stall, o_valid;
    logic signed [FIELD_WIDTH-1:0] o_result_numerator, o_result_denominator;

    rational_arithmetic_reduce_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_command(i_command),
        .i_a_numerator(i_a_numerator), .i_a_denominator(i_a_denominator),
        .i_b_numerator(i_b_numerator), .i_b_denominator(i_b_denominator),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_result_numerator(o_result_numerator),
        .o_result_denominator(o_result_denominator)
    );

    always #5 i_clk = ~i_clk;

    t_op   pending_ops[$];
    t_frac expected_fracs[$];
    int    mismatch_count = 0;
    int    send_idle_pct = 28;
    int    recv_idle_pct = 55;
    bit    hold_sender = 1'b0;
    bit    stimulus_done = 1'b0;

    function automatic logic [W-1:0] magnitude(logic [W-1:0] x);
        return x[W-1] ? -x : x;
    endfunction

    function automatic logic [W-1:0] div_exact(logic [W-1:0] x, logic [W-1:0] g);
        logic [W-1:0] q;
        q = magnitude(x) / g;
        return x[W-1] ? -q : q;
    endfunction

    function automatic t_frac reduce_result(t_op op);
        logic [W-1:0] n, d, x, y, t;
        t_frac r;
        case (op.command)
            CMD_ADD: begin
                n = op.an * op.bd + op.ad * op.bn;
                d = op.ad * op.bd;
            end
            CMD_SUB: begin
                n = op.an * op.bd - op.ad * op.bn;
                d = op.ad * op.bd;
            end
            CMD_MUL: begin
                n = op.an * op.bn;
                d = op.ad * op.bd;
            end
            CMD_DIV: begin
                n = op.an * op.bd;
                d = op.ad * op.bn;
            end
            CMD_INC: begin
                n = op.an + op.ad;
                d = op.ad;
            end
            default: begin
                n = op.an;
                d = op.ad;
            end
        endcase
        if (d[W-1]) begin
            n = -n;
            d = -d;
        end
        if (n != 0 && d != 0) begin
            x = magnitude(n);
            y = magnitude(d);
            while (y != 0) begin
                t = x % y;
                x = y;
                y = t;
            end
            if (x > 1) begin
                n = div_exact(n, x);
                d = div_exact(d, x);
            end
        end
        r.num = n;
        r.den = d;
        return r;
    endfunction

    // mix of edge values, small values and full-range noise
    function automatic logic [W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return '0;
            3: return $urandom_range(0, 1) ? 32'd1 : 32'hffff_ffff;
            4, 5: return W'($signed($urandom_range(0, 200)) - 100);
            6: return W'($signed($urandom_range(0, 100000)) - 50000) * W'($urandom_range(1, 12));
            default: return $urandom;
        endcase
    endfunction

    task automatic push_op(logic [2:0] c, logic [W-1:0] an, logic [W-1:0] ad,
                           logic [W-1:0] bn, logic [W-1:0] bd);
        t_op op;
        op.command = c;
        op.an = an;
        op.ad = ad;
        op.bn = bn;
        op.bd = bd;
        pending_ops.push_back(op);
    endtask

    task automatic wait_drained();
        while (pending_ops.size() != 0 || i_valid || expected_fracs.size() != 0)
            @(posedge i_clk);
    endtask

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_valid || !o_stall) begin
                if (pending_ops.size() != 0 && !hold_sender
                        && $urandom_range(0, 99) >= send_idle_pct) begin
                    t_op op;
                    op = pending_ops.pop_front();
                    expected_fracs.push_back(reduce_result(op));
                    i_valid <= 1'b1;
                    i_command <= op.command;
                    i_a_numerator <= op.an;
                    i_a_denominator <= op.ad;
                    i_b_numerator <= op.bn;
                    i_b_denominator <= op.bd;
                end else begin
                    i_valid <= 1'b0;
                end
            end
            i_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_fracs.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected transaction: %h/%h",
                             o_result_numerator, o_result_denominator);
            end else begin
                t_frac e;
                e = expected_fracs.pop_front();
                if (o_result_numerator !== e.num || o_result_denominator !== e.den) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: expected %h/%h got %h/%h",
                                 e.num, e.den, o_result_numerator, o_result_denominator);
                end
            end
        end
    end

    initial begin
        int c;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every command, extremes and zero parts
        for (c = 0; c < 8; c++)
            push_op(c[2:0], 32'd6, 32'd4, 32'd3, 32'hffff_fffa);
        push_op(CMD_ADD, 32'd0, 32'hffff_fffa, 32'd0, 32'd1);
        push_op(CMD_DIV, 32'd5, 32'd7, 32'd0, 32'd3);
        push_op(CMD_MUL, 32'd5, 32'd0, 32'd2, 32'd3);
        push_op(CMD_SPARE_HI, 32'd4, 32'h8000_0000, 32'd0, 32'd0);
        push_op(CMD_SPARE_HI, 32'h8000_0000, 32'd3, 32'd0, 32'd0);
        push_op(CMD_SPARE_HI, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff, 32'hffff_ffff);
        push_op(CMD_INC, 32'h7fff_ffff, 32'd1, 32'h7fff_ffff, 32'h8000_0000);
        push_op(CMD_SUB, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        push_op(CMD_MUL, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
        push_op(CMD_DIV, 32'd12, 32'hffff_fff8, 32'hffff_fff7, 32'd18);
        push_op(CMD_SPARE_LO, 32'd0, 32'd0, 32'd0, 32'd0);
        wait_drained();

        // hold the sender while each third of the ops is queued, then drain
        hold_sender = 1'b1;
        for (c = 0; c < N_RANDOM; c++) begin
            push_op(3'($urandom_range(0, 7)), pick_value(), pick_value(),
                    pick_value(), pick_value());
            if (c == N_RANDOM / 3) begin
                hold_sender = 1'b0;
                wait_drained();
                send_idle_pct = 55;
                recv_idle_pct = 28;
                hold_sender = 1'b1;
            end else if (c == 2 * N_RANDOM / 3) begin
                hold_sender = 1'b0;
                wait_drained();
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_sender = 1'b1;
            end
        end
        hold_sender = 1'b0;
        wait_drained();
        repeat (200) @(posedge i_clk);
        if (mismatch_count == 0 && expected_fracs.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial begin
        #30_000_000;
        $display("tb failed");
        $finish;
    end
endmodule

// File: rational_arithmetic_reduce_top.f
hw/rtl/rar_pkg.sv
hw/rtl/rar_mac.sv
hw/rtl/rar_sub.sv
hw/rtl/rational_arithmetic_reduce_top.sv
verif/tb.sv
